### hdl/dq_pkg.sv
// shared types, request codes and constants for the double-ended queue
package dq_pkg;

    localparam int DQ_DEPTH = 64;
    localparam int WORD_W   = 32;
    localparam int CFG_W    = 7;
    localparam int REQ_W    = 3;

    localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;
    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd5;
    localparam logic [REQ_W-1:0] REQ_IS_EMPTY   = 3'd6;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the accepted request
        logic exec;       // update pointers, write or read the store
        logic take_read;  // move the read word into the result register
    } dq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_read;  // request is a pop or peek on a non-empty queue
    } dq_stat_t;

endpackage

### hdl/dq_ctrl.sv
// sequencing state machine of the double-ended queue
module dq_ctrl
    import dq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dq_stat_t stat,
    output dq_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_RDWAIT = 4'b0100,
        ST_RESP   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.exec      = 1'b0;
        cmd.take_read = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.need_read)
                begin
                    state_next = ST_RDWAIT;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RDWAIT:
            begin
                cmd.take_read = 1'b1;
                state_next    = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_RESP);

endmodule

### hdl/dq_datapath.sv
// circular buffer store, pointers, capacity register and result register
module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH = DQ_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dq_cmd_t                  cmd,
    output dq_stat_t                 stat,
    input  logic [REQ_W-1:0]         req_type,
    input  logic signed [WORD_W-1:0] push_value,
    input  logic                     cfg_wr,
    input  logic [CFG_W-1:0]         cfg_data,
    output logic signed [WORD_W-1:0] result_value,
    output logic                     ok
);

    localparam int AW    = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int SW    = AW + 1;
    localparam int CW    = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    logic signed [WORD_W-1:0] mem [DEPTH];

    logic [REQ_W-1:0]         req_reg;
    logic signed [WORD_W-1:0] value_reg;
    logic [CFG_W-1:0]         cap_reg;
    logic [AW-1:0]            front_reg;
    logic [OCC_W-1:0]         occ_reg;
    logic signed [WORD_W-1:0] rd_data_reg;
    logic signed [WORD_W-1:0] result_reg;
    logic                     ok_reg;

    logic [AW-1:0]            front_next;
    logic [OCC_W-1:0]         occ_next;
    logic signed [WORD_W-1:0] result_next;
    logic                     ok_next;

    logic [CW-1:0] cap_c;
    logic [CW-1:0] eff_cap;
    logic          empty;
    logic          can_push;
    logic          is_push;
    logic          is_access;
    logic          at_back;
    logic [SW-1:0] end_sum;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] end_slot;
    logic [AW-1:0] tail_slot;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    assign cap_c     = CW'(cap_reg);
    assign eff_cap   = (cap_c > DEPTH_C) ? DEPTH_C : cap_c;
    assign empty     = (occ_reg == '0);
    assign can_push  = (CW'(occ_reg) < eff_cap);
    assign is_push   = (req_reg == REQ_PUSH_BACK) || (req_reg == REQ_PUSH_FRONT);
    assign is_access = req_reg inside {REQ_POP_BACK, REQ_POP_FRONT,
                                       REQ_PEEK_BACK, REQ_PEEK_FRONT};
    assign at_back   = req_reg inside {REQ_POP_BACK, REQ_PEEK_BACK};

    // front + occupancy stays below twice the depth, so one subtract wraps it
    assign end_sum   = SW'(front_reg) + SW'(occ_reg);
    assign tail_sum  = end_sum - SW'(1);
    assign end_slot  = (end_sum >= DEPTH_S) ? AW'(end_sum - DEPTH_S) : AW'(end_sum);
    assign tail_slot = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - AW'(1);
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + AW'(1);

    assign stat.need_read = is_access && !empty;

    always_comb
    begin
        front_next  = front_reg;
        occ_next    = occ_reg;
        result_next = '0;
        ok_next     = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = end_slot;
        rd_en       = 1'b0;
        rd_addr     = at_back ? tail_slot : front_reg;
        if (is_push)
        begin
            if (can_push)
            begin
                wr_en       = 1'b1;
                occ_next    = occ_reg + OCC_W'(1);
                result_next = WORD_W'(1);
                ok_next     = 1'b1;
                if (req_reg == REQ_PUSH_FRONT)
                begin
                    wr_addr    = front_dec;
                    front_next = front_dec;
                end
            end
        end
        else if (is_access)
        begin
            if (empty)
            begin
                result_next = EMPTY_WORD;
            end
            else
            begin
                rd_en   = 1'b1;
                ok_next = 1'b1;
                if (req_reg == REQ_POP_BACK)
                begin
                    occ_next = occ_reg - OCC_W'(1);
                end
                else if (req_reg == REQ_POP_FRONT)
                begin
                    occ_next   = occ_reg - OCC_W'(1);
                    front_next = front_inc;
                end
            end
        end
        else if (req_reg == REQ_IS_EMPTY)
        begin
            result_next = WORD_W'(empty);
            ok_next     = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (cmd.exec && rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_type;
            value_reg <= push_value;
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
        else if (cmd.take_read)
        begin
            result_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            front_reg <= '0;
            occ_reg   <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.exec)
            begin
                front_reg <= front_next;
                occ_reg   <= occ_next;
                ok_reg    <= ok_next;
            end
        end
    end

    assign result_value = result_reg;
    assign ok           = ok_reg;

endmodule

### hdl/double_ended_queue.sv
// top level of the bounded double-ended queue
// Bounded double-ended queue of signed 32-bit words held in a circular buffer of
// DEPTH entries. One request is handled at a time. A push, an empty query, an unused
// code or a pop or peek on an empty queue goes from acceptance through the execute
// state to the response state; a pop or peek of a held word also passes a read-wait
// state, because the store has one registered read port and the sequencer moves the
// read word into the result register in a state of its own. The result is held until
// out_ready is high, and the next request is accepted in the cycle after it is taken.
// The capacity register (reset 64, clipped to DEPTH) may be written only while no
// request is outstanding. Pops and peeks on an empty queue return -1 with ok low; a
// push on a full queue returns 0.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = DQ_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [REQ_W-1:0]         req_type,
    input  logic signed [WORD_W-1:0] push_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] result_value,
    output logic                     ok,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_W-1:0]         cfg_data
);

    dq_cmd_t  cmd;
    dq_stat_t stat;

    assign cfg_ready = 1'b1;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .push_value   (push_value),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .result_value (result_value),
        .ok           (ok)
    );

endmodule

### hdl/dq_checker.sv
// port-level checks for the double-ended queue, bound to the top level
module dq_checker
    import dq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [WORD_W-1:0] result_value,
    input logic                     ok
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(ok))
        else $error("result changed while stalled");

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid)
        else $error("request accepted while a result is pending");

    // a result never shows up in the cycle right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid && !in_ready)
        else $error("sequencer skipped the execute step");

    // failed requests answer 0 or -1 only
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> result_value == '0 || result_value == EMPTY_WORD)
        else $error("failed request with unexpected value");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
